### rtl/mvm_pkg.sv
// Shared types and constants for the matrix-vector multiply block.
package mvm_pkg;

    localparam int OPERAND_BITS   = 16;
    localparam int PRODUCT_BITS   = 2 * OPERAND_BITS;
    localparam int RESULT_BITS    = 32;
    localparam int ROW_BITS       = 6;
    localparam int SIZE_BITS      = 7;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 7;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MATRIX_SIZE  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COLUMN_MAJOR = 2'd1;

    localparam logic [SIZE_BITS-1:0] SIZE_RESET = 7'd64;

    // Item kinds
    localparam logic KIND_VECTOR = 1'b0;
    localparam logic KIND_MATRIX = 1'b1;

    localparam logic signed [RESULT_BITS-1:0] RESULT_MAX = {1'b0, {(RESULT_BITS-1){1'b1}}};
    localparam logic signed [RESULT_BITS-1:0] RESULT_MIN = {1'b1, {(RESULT_BITS-1){1'b0}}};

    typedef struct packed {
        logic                           kind;
        logic signed [OPERAND_BITS-1:0] element_value;
    } in_item_t;

    typedef struct packed {
        logic [ROW_BITS-1:0]           row_number;
        logic signed [RESULT_BITS-1:0] result_value;
        logic                          last_result;
        logic                          saturated;
    } out_item_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_vec;
        logic start;
        logic mul;
        logic acc;
        logic emit_row;
        logic drain_rd;
        logic drain_emit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic column_major;
        logic row_done;
        logic prod_done;
        logic drain_last;
        logic out_free;
    } dp_status_t;

endpackage

### rtl/mvm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/mvm_ctrl.sv
// Sequencing state machine for the matrix-vector multiply block.
module mvm_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic                   item_kind,
    input  mvm_pkg::dp_status_t    status,
    output logic                   item_stall,
    output mvm_pkg::ctrl_cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_MUL       = 3'd1;
    localparam logic [2:0] ST_ACC       = 3'd2;
    localparam logic [2:0] ST_EMIT      = 3'd3;
    localparam logic [2:0] ST_DRAIN_RD  = 3'd4;
    localparam logic [2:0] ST_DRAIN_OUT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign item_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (item_kind == mvm_pkg::KIND_VECTOR)
                    begin
                        cmd.load_vec = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (!status.column_major && status.row_done)
                begin
                    state_next = ST_EMIT;
                end
                else if (status.column_major && status.prod_done)
                begin
                    state_next = ST_DRAIN_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_row = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DRAIN_RD:
            begin
                cmd.drain_rd = 1'b1;
                state_next   = ST_DRAIN_OUT;
            end
            ST_DRAIN_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.drain_emit = 1'b1;
                    state_next     = status.drain_last ? ST_IDLE : ST_DRAIN_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/mvm_datapath.sv
// Datapath: vector and accumulator stores, multiplier, accumulators, output register.
module mvm_datapath #(
    parameter int MAX_DIM = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [mvm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [mvm_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  mvm_pkg::in_item_t                    item,
    input  mvm_pkg::ctrl_cmd_t                   cmd,
    output mvm_pkg::dp_status_t                  status,
    output logic                                 result_valid,
    output mvm_pkg::out_item_t                   result,
    input  logic                                 result_stall
);

    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int ACC_W = mvm_pkg::PRODUCT_BITS + IDX_W + 1;
    localparam logic [mvm_pkg::SIZE_BITS-1:0] MAX_SIZE = mvm_pkg::SIZE_BITS'(MAX_DIM);
    localparam int RESULT_TOP = mvm_pkg::RESULT_BITS - 1;

    logic [mvm_pkg::SIZE_BITS-1:0] size_reg, size_next;
    logic                          col_reg, col_next;
    logic [IDX_W:0]                vcount_reg, vcount_next;
    logic [IDX_W-1:0]              inner_reg, inner_next;
    logic [IDX_W-1:0]              outer_reg, outer_next;
    logic [IDX_W-1:0]              drain_reg, drain_next;
    logic signed [ACC_W-1:0]       row_acc_reg, row_acc_next;
    logic signed [mvm_pkg::OPERAND_BITS-1:0] operand_reg;
    logic signed [mvm_pkg::PRODUCT_BITS-1:0] product_reg;
    logic                          out_valid_reg, out_valid_next;
    mvm_pkg::out_item_t            out_reg;

    logic [mvm_pkg::SIZE_BITS-1:0] dim;
    logic [IDX_W-1:0]              last_idx;
    logic [IDX_W-1:0]              vec_waddr;
    logic [IDX_W-1:0]              vec_raddr;
    logic [mvm_pkg::OPERAND_BITS-1:0] vec_rdata;
    logic [IDX_W-1:0]              acc_raddr;
    logic [ACC_W-1:0]              acc_rdata;
    logic signed [ACC_W-1:0]       col_base;
    logic signed [ACC_W-1:0]       col_sum;
    logic signed [ACC_W-1:0]       row_sum;
    logic                          acc_we;
    logic signed [ACC_W-1:0]       emit_acc;
    logic [ACC_W-RESULT_TOP-1:0]   emit_hi;
    logic                          emit_over;
    logic                          out_load;

    // Clamp the configured size to 1..MAX_DIM
    always_comb
    begin
        priority if (size_reg == '0)
        begin
            dim = mvm_pkg::SIZE_BITS'(1);
        end
        else if (size_reg > MAX_SIZE)
        begin
            dim = MAX_SIZE;
        end
        else
        begin
            dim = size_reg;
        end
    end

    assign last_idx  = IDX_W'(dim - mvm_pkg::SIZE_BITS'(1));
    assign vec_waddr = (mvm_pkg::SIZE_BITS'(vcount_reg) >= dim) ? '0 : vcount_reg[IDX_W-1:0];
    assign vec_raddr = col_reg ? outer_reg : inner_reg;
    assign acc_raddr = cmd.drain_rd ? drain_reg : inner_reg;

    mvm_ram #(
        .WIDTH (mvm_pkg::OPERAND_BITS),
        .DEPTH (MAX_DIM)
    ) u_vector_store (
        .clk   (clk),
        .we    (cmd.load_vec),
        .waddr (vec_waddr),
        .wdata (item.element_value),
        .re    (cmd.start),
        .raddr (vec_raddr),
        .rdata (vec_rdata)
    );

    // The first column writes fresh sums, so the store never needs clearing
    assign col_base = (outer_reg == '0) ? '0 : $signed(acc_rdata);
    assign col_sum  = col_base + ACC_W'(product_reg);
    assign row_sum  = row_acc_reg + ACC_W'(product_reg);
    assign acc_we   = cmd.acc && col_reg;

    mvm_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_DIM)
    ) u_accumulator_store (
        .clk   (clk),
        .we    (acc_we),
        .waddr (inner_reg),
        .wdata (col_sum),
        .re    (cmd.start || cmd.drain_rd),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    // Saturate the emitted sum to the result range
    assign emit_acc  = cmd.drain_emit ? $signed(acc_rdata) : row_acc_reg;
    assign emit_hi   = emit_acc[ACC_W-1:RESULT_TOP];
    assign emit_over = !((&emit_hi) || !(|emit_hi));
    assign out_load  = cmd.emit_row || cmd.drain_emit;

    always_comb
    begin
        size_next    = size_reg;
        col_next     = col_reg;
        vcount_next  = vcount_reg;
        inner_next   = inner_reg;
        outer_next   = outer_reg;
        drain_next   = drain_reg;
        row_acc_next = row_acc_reg;
        priority if (cfg_write)
        begin
            unique case (cfg_index)
                mvm_pkg::CFG_MATRIX_SIZE:  size_next = cfg_data;
                mvm_pkg::CFG_COLUMN_MAJOR: col_next  = cfg_data[0];
                default: ;
            endcase
            if (cfg_index == mvm_pkg::CFG_MATRIX_SIZE || cfg_index == mvm_pkg::CFG_COLUMN_MAJOR)
            begin
                vcount_next  = '0;
                inner_next   = '0;
                outer_next   = '0;
                row_acc_next = '0;
            end
        end
        else if (cmd.load_vec)
        begin
            // A vector element abandons any partial product
            vcount_next  = {1'b0, vec_waddr} + (IDX_W+1)'(1);
            inner_next   = '0;
            outer_next   = '0;
            row_acc_next = '0;
        end
        else if (cmd.acc)
        begin
            if (!col_reg)
            begin
                row_acc_next = row_sum;
                if (inner_reg != last_idx)
                begin
                    inner_next = inner_reg + IDX_W'(1);
                end
            end
            else if (inner_reg == last_idx)
            begin
                inner_next = '0;
                outer_next = (outer_reg == last_idx) ? '0 : outer_reg + IDX_W'(1);
                drain_next = '0;
            end
            else
            begin
                inner_next = inner_reg + IDX_W'(1);
            end
        end
        else if (cmd.emit_row)
        begin
            row_acc_next = '0;
            inner_next   = '0;
            outer_next   = (outer_reg == last_idx) ? '0 : outer_reg + IDX_W'(1);
        end
        else if (cmd.drain_emit)
        begin
            drain_next = drain_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= mvm_pkg::SIZE_RESET;
            col_reg       <= 1'b0;
            vcount_reg    <= '0;
            inner_reg     <= '0;
            outer_reg     <= '0;
            drain_reg     <= '0;
            row_acc_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            size_reg      <= size_next;
            col_reg       <= col_next;
            vcount_reg    <= vcount_next;
            inner_reg     <= inner_next;
            outer_reg     <= outer_next;
            drain_reg     <= drain_next;
            row_acc_reg   <= row_acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            operand_reg <= item.element_value;
        end
        if (cmd.mul)
        begin
            product_reg <= operand_reg * $signed(vec_rdata);
        end
        if (out_load)
        begin
            out_reg.row_number   <= cmd.drain_emit ? mvm_pkg::ROW_BITS'(drain_reg)
                                                   : mvm_pkg::ROW_BITS'(outer_reg);
            out_reg.last_result  <= cmd.drain_emit ? (drain_reg == last_idx)
                                                   : (outer_reg == last_idx);
            out_reg.saturated    <= emit_over;
            out_reg.result_value <= emit_over
                ? (emit_acc[ACC_W-1] ? mvm_pkg::RESULT_MIN : mvm_pkg::RESULT_MAX)
                : emit_acc[RESULT_TOP:0];
        end
    end

    assign status.column_major = col_reg;
    assign status.row_done     = (inner_reg == last_idx);
    assign status.prod_done    = (inner_reg == last_idx) && (outer_reg == last_idx);
    assign status.drain_last   = (drain_reg == last_idx);
    assign status.out_free     = !out_valid_reg || !result_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

### rtl/matrix_vector_multiply.sv
// Top level of the matrix-vector multiply block y = A*x.
//
// Input channel (item_valid / item_stall / item) carries vector elements
// (kind 0) that fill the vector store in order, then matrix elements (kind 1).
// Output channel (result_valid / result_stall / result) carries y[i] in Q8.24,
// clipped to 32 bits, with last_result on y[n-1].
// Configuration: cfg_write with cfg_index 0 sets the size, 1 the layout; any
// write to either register abandons the current product and vector load.
//
// Sequencing: the block stays idle after a vector element, so vector elements
// are taken back to back. A matrix element steps through accept with store read,
// multiply and accumulate before the next item is taken. In row-major layout the
// last element of a row adds a step that loads the result register once the
// output is free. In column-major layout the last element starts a drain that,
// per result, reads the accumulator store then loads the output; no item is
// taken meanwhile. The steps come from registered store reads and one multiplier.
// A stalled receiver holds the output register; the block keeps taking items
// until it needs to load a new result, then waits.
// Reset empties the output register and returns to size 64, row-major.
// MAX_DIM ranges from 2 to 64.
module matrix_vector_multiply #(
    parameter int MAX_DIM = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [mvm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [mvm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  mvm_pkg::in_item_t                  item,
    output logic                               result_valid,
    input  logic                               result_stall,
    output mvm_pkg::out_item_t                 result
);

    mvm_pkg::ctrl_cmd_t  cmd;
    mvm_pkg::dp_status_t status;

    mvm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_kind  (item.kind),
        .status     (status),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    mvm_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result       (result),
        .result_stall (result_stall)
    );

    // At most one command per cycle
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
        else $error("controller issued more than one command");

    // Multiply and accumulate follow a matrix element transfer in order
    assert property (@(posedge clk) disable iff (!rst_n) cmd.start |=> cmd.mul)
        else $error("multiply did not follow start");

    assert property (@(posedge clk) disable iff (!rst_n) cmd.mul |=> cmd.acc)
        else $error("accumulate did not follow multiply");

    // A vector element transfer never produces a result by itself
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && item.kind == mvm_pkg::KIND_VECTOR && !result_valid)
        |=> !result_valid)
        else $error("result appeared after a vector element");

endmodule

### dv/mvm_result_checker.sv
// Checker for the matrix-vector multiply block: predicts y and compares each result transfer.
module mvm_result_checker
    import mvm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      item_valid,
    input  logic                      item_stall,
    input  in_item_t                  item,
    input  logic                      result_valid,
    input  logic                      result_stall,
    input  out_item_t                 result,
    output int                        failures,
    output int                        pending
);

    localparam int DIM_MAX = 64;

    logic [SIZE_BITS-1:0]    size_reg;
    logic                    col_major_reg;
    logic signed [15:0]      x_mem [DIM_MAX];
    // 64 products of at most 2^30 cannot overflow 64 bits
    logic signed [63:0]      column_sums [DIM_MAX];
    logic signed [63:0]      row_sum;
    int                      x_fill;
    int                      inner_pos;
    int                      outer_pos;
    out_item_t               y_queue [$];

    function automatic int active_size();
        if (size_reg == 0)
        begin
            return 1;
        end
        if (size_reg > DIM_MAX)
        begin
            return DIM_MAX;
        end
        return int'(size_reg);
    endfunction

    task automatic clear_position();
        row_sum   = '0;
        inner_pos = 0;
        outer_pos = 0;
    endtask

    task automatic queue_y(input int row, input logic signed [63:0] sum, input logic last);
        out_item_t y;
        y.row_number  = ROW_BITS'(row);
        y.last_result = last;
        y.saturated   = 1'b0;
        y.result_value = sum[RESULT_BITS-1:0];
        if (sum > RESULT_MAX)
        begin
            y.result_value = RESULT_MAX;
            y.saturated    = 1'b1;
        end
        else if (sum < RESULT_MIN)
        begin
            y.result_value = RESULT_MIN;
            y.saturated    = 1'b1;
        end
        y_queue.push_back(y);
    endtask

    task automatic step_product(input in_item_t it);
        int                 n;
        logic signed [63:0] prod;
        n = active_size();
        if (it.kind == KIND_VECTOR)
        begin
            if (x_fill >= n)
            begin
                x_fill = 0;
            end
            x_mem[x_fill] = it.element_value;
            x_fill++;
            clear_position();
        end
        else
        begin
            if (inner_pos >= n)
            begin
                inner_pos = 0;
            end
            if (outer_pos >= n)
            begin
                outer_pos = 0;
            end
            if (!col_major_reg)
            begin
                // outer is the row, inner the column
                prod = $signed(it.element_value) * $signed(x_mem[inner_pos]);
                row_sum = row_sum + prod;
                if (inner_pos == n - 1)
                begin
                    queue_y(outer_pos, row_sum, outer_pos == n - 1);
                    row_sum   = '0;
                    inner_pos = 0;
                    outer_pos = (outer_pos == n - 1) ? 0 : outer_pos + 1;
                end
                else
                begin
                    inner_pos++;
                end
            end
            else
            begin
                // outer is the column, inner the row
                if (inner_pos == 0 && outer_pos == 0)
                begin
                    for (int r = 0; r < n; r++)
                    begin
                        column_sums[r] = '0;
                    end
                end
                prod = $signed(it.element_value) * $signed(x_mem[outer_pos]);
                column_sums[inner_pos] = column_sums[inner_pos] + prod;
                if (inner_pos == n - 1)
                begin
                    inner_pos = 0;
                    if (outer_pos == n - 1)
                    begin
                        for (int r = 0; r < n; r++)
                        begin
                            queue_y(r, column_sums[r], r == n - 1);
                        end
                        outer_pos = 0;
                    end
                    else
                    begin
                        outer_pos++;
                    end
                end
                else
                begin
                    inner_pos++;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            size_reg      = SIZE_RESET;
            col_major_reg = 1'b0;
            for (int r = 0; r < DIM_MAX; r++)
            begin
                x_mem[r]       = '0;
                column_sums[r] = '0;
            end
            x_fill = 0;
            clear_position();
            y_queue.delete();
            failures = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (y_queue.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected result: expected none, got row %0d value %0d",
                             $time, result.row_number, result.result_value);
                end
                else
                begin
                    want = y_queue.pop_front();
                    if (result !== want)
                    begin
                        failures++;
                        $display("%0t: y mismatch: expected row %0d value %0d last %0b sat %0b",
                                 $time, want.row_number, want.result_value,
                                 want.last_result, want.saturated);
                        $display("%0t:             got row %0d value %0d last %0b sat %0b",
                                 $time, result.row_number, result.result_value,
                                 result.last_result, result.saturated);
                    end
                end
            end
            if (cfg_write)
            begin
                if (cfg_index == CFG_MATRIX_SIZE || cfg_index == CFG_COLUMN_MAJOR)
                begin
                    if (cfg_index == CFG_MATRIX_SIZE)
                    begin
                        size_reg = cfg_data[SIZE_BITS-1:0];
                    end
                    else
                    begin
                        col_major_reg = cfg_data[0];
                    end
                    x_fill = 0;
                    clear_position();
                end
            end
            if (item_valid && !item_stall)
            begin
                step_product(item);
            end
        end
        pending = y_queue.size();
    end

endmodule

### dv/tb_matrix_vector_multiply.sv
// Testbench top for the matrix-vector multiply block: stimulus, idling and verdict.
module tb_matrix_vector_multiply;
    import mvm_pkg::*;

    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS   = 35;
    localparam int BIG_SIZE      = 64;
    localparam int OVER_SIZE     = 127;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      item_valid;
    logic                      item_stall;
    in_item_t                  item;
    logic                      result_valid;
    logic                      result_stall;
    out_item_t                 result;
    int                        failures;
    int                        pending;

    int tx_idle_pct;
    int rx_idle_pct;
    int items_sent;
    int active_n;
    int x_fill;
    int x_written;

    matrix_vector_multiply i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    mvm_result_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .failures     (failures),
        .pending      (pending)
    );

    always #5 clk = ~clk;

    function automatic logic [OPERAND_BITS-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return OPERAND_BITS'($urandom);
        endcase
    endfunction

    // All tasks below start and end at a falling edge.
    task automatic send_item(input logic kind, input logic [OPERAND_BITS-1:0] value);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{kind: kind, element_value: value};
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_x(input logic [OPERAND_BITS-1:0] value);
        if (x_fill >= active_n)
        begin
            x_fill = 0;
        end
        x_fill++;
        if (x_fill > x_written)
        begin
            x_written = x_fill;
        end
        send_item(KIND_VECTOR, value);
    endtask

    task automatic load_x(input int count);
        repeat (count)
        begin
            send_x(pick_value());
        end
    endtask

    // Hold the sender until every expected result has been transferred.
    task automatic hold_for_results();
        item_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic settle();
        hold_for_results();
        repeat (SETTLE_CYCLES)
        begin
            @(negedge clk);
        end
    endtask

    task automatic stream_a(input int count, input bit noisy);
        repeat (count)
        begin
            if (noisy && $urandom_range(0, 39) == 0)
            begin
                send_x(pick_value());
            end
            if (noisy && $urandom_range(0, 59) == 0)
            begin
                hold_for_results();
            end
            send_item(KIND_MATRIX, pick_value());
        end
    endtask

    // Enter with the block idle and item_valid low.
    task automatic configure(input int size_raw, input logic col);
        logic [CFG_DATA_BITS-1:0] col_word;
        bit                       size_first;
        col_word    = CFG_DATA_BITS'($urandom);
        col_word[0] = col;
        size_first  = 1'($urandom_range(0, 1));
        cfg_write <= 1'b1;
        cfg_index <= size_first ? CFG_MATRIX_SIZE : CFG_COLUMN_MAJOR;
        cfg_data  <= size_first ? CFG_DATA_BITS'(size_raw) : col_word;
        @(negedge clk);
        cfg_index <= size_first ? CFG_COLUMN_MAJOR : CFG_MATRIX_SIZE;
        cfg_data  <= size_first ? col_word : CFG_DATA_BITS'(size_raw);
        @(negedge clk);
        if ($urandom_range(0, 2) == 0)
        begin
            // an index past the register list must be ignored
            cfg_index <= CFG_INDEX_BITS'($urandom_range(CFG_COLUMN_MAJOR + 1,
                                                        (1 << CFG_INDEX_BITS) - 1));
            cfg_data  <= CFG_DATA_BITS'($urandom);
            @(negedge clk);
        end
        cfg_write <= 1'b0;
        active_n = (size_raw == 0) ? 1 : (size_raw > BIG_SIZE) ? BIG_SIZE : size_raw;
        x_fill   = 0;
    endtask

    task automatic random_setting();
        int   size_raw;
        logic col;
        int   rows;
        size_raw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        col      = 1'($urandom_range(0, 1));
        settle();
        configure(size_raw, col);
        if (x_written < active_n || $urandom_range(0, 3) != 0)
        begin
            load_x(active_n + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0));
        end
        repeat ($urandom_range(1, 3))
        begin
            rows = col ? active_n : $urandom_range(1, active_n);
            stream_a(rows * active_n, 1'b1);
        end
        if ($urandom_range(0, 2) == 0)
        begin
            // possibly leave a partial product for the next write to abandon
            stream_a($urandom_range(1, active_n * active_n), 1'b1);
        end
    endtask

    initial
    begin : stimulus
        int target;
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_MATRIX_SIZE;
        cfg_data     = '0;
        item_valid   = 1'b0;
        item         = '0;
        tx_idle_pct  = 27;
        rx_idle_pct  = 81;
        items_sent   = 0;
        active_n     = BIG_SIZE;
        x_fill       = 0;
        x_written    = 0;
        repeat (6)
        begin
            @(negedge clk);
        end
        rst_n <= 1'b1;
        @(negedge clk);

        // Row-major n=3: clip low, clip high, then a zero last row.
        configure(3, 1'b0);
        repeat (3) send_x(16'h8000);
        repeat (3) send_item(KIND_MATRIX, 16'h7FFF);
        repeat (3) send_item(KIND_MATRIX, 16'h8000);
        send_item(KIND_MATRIX, 16'h0000);
        send_item(KIND_MATRIX, 16'h0001);
        send_item(KIND_MATRIX, 16'hFFFF);
        // Column-major on the old vector after the write cleared the load count.
        settle();
        configure(3, 1'b1);
        stream_a(9, 1'b0);
        // A vector load drops the partial product.
        send_item(KIND_MATRIX, 16'h7FFF);
        send_x(16'h7FFF);
        // Size zero acts as one; the second load wraps to entry 0.
        settle();
        configure(0, 1'b1);
        send_item(KIND_MATRIX, 16'h8000);
        send_x(16'h8000);
        send_x(16'h7FFF);
        send_item(KIND_MATRIX, 16'h8000);

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 81 : 0;
            rx_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 27 : 0;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                random_setting();
            end
        end

        // Oversized setting clamps to full size: load the whole vector, run one row.
        settle();
        configure(OVER_SIZE, 1'b0);
        load_x(BIG_SIZE);
        stream_a(BIG_SIZE, 1'b0);

        settle();
        if (failures == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial
    begin : receiver
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            result_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_write || (item_valid && !item_stall) ||
                (result_valid && !result_stall))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
